[hw/rtl/sop_pkg.sv]
package sop_pkg;

  // Sine table entry: unsigned Q1.30, never above 1.0, so 31 bits
  localparam int SINE_W = 31;
  // Shared multiplier operands and product
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int AMP_W = 16;
  localparam int PHASE_W = 32;
  localparam int PCM_W = 16;
  localparam int PCM_MAG_W = PCM_W - 1;
  localparam int Q30_SHIFT = 30;
  localparam int GAIN_SHIFT = 15;

  localparam logic [63:0] HALF_PI_Q30 = 64'h0000_0000_6487_ED51;
  localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;
  localparam int TAYLOR_TERMS = 7;
  // (2n)(2n+1) for n = 1..7
  localparam int unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

  localparam logic [PCM_MAG_W-1:0] PCM_MAG_MAX = {PCM_MAG_W{1'b1}};

  localparam logic CFG_PHASE_STEP = 1'b0;
  localparam logic CFG_AMPLITUDE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SCALE,
    ST_WRITE
  } sop_state_t;

  typedef enum logic {
    MUL_GAIN,
    MUL_SCALE
  } mul_op_t;

  typedef struct packed {
    logic    en;
    mul_op_t op;
  } mul_ctl_t;

  // Quarter-wave sine, Taylor series, returned in Q1.30; evaluated at elaboration only
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] t;
    int          n;
    x = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
    x2 = (x * x) >> Q30_SHIFT;
    s = x;
    t = x;
    for (n = 0; n < TAYLOR_TERMS; n++) begin
      t = ((t * x2) >> Q30_SHIFT) / 64'(TAYLOR_DIV[3'(n)]);
      if ((n % 2) == 0) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

[hw/rtl/sop_rom.sv]
module sop_rom
  import sop_pkg::*;
#(
  parameter int ADDR_BITS = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_BITS:0] rd_addr,
  output logic [SINE_W-1:0] rd_data
);

  localparam int DEPTH = (1 << ADDR_BITS) + 1;

  typedef logic [SINE_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[(ADDR_BITS+1)'(k)] = quarter_sine(k, ADDR_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [SINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/sop_mul.sv]
module sop_mul
  import sop_pkg::*;
(
  input  logic               clk,
  input  mul_ctl_t           ctl,
  input  logic [SINE_W-1:0]  sine,
  input  logic [AMP_W-1:0]   amplitude,
  input  logic [MUL_B_W-1:0] full_scale,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0]  prod_r;
  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;

  // First pass: sine times gain; second pass: (previous >> 15) times full scale
  always_comb begin
    unique case (ctl.op)
      MUL_GAIN: begin
        op_a = MUL_A_W'(sine);
        op_b = MUL_B_W'(amplitude);
      end
      MUL_SCALE: begin
        op_a = prod_r[GAIN_SHIFT +: MUL_A_W];
        op_b = full_scale;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

[hw/rtl/sine_oscillator_pcm_top.sv]
// Sine oscillator: one tick word in, one signed PCM word out.
// A tick passes through the table read, a gain pass and a scale pass through the
// shared multiplier, then the output register. A new tick is taken only once the
// word is in the output register; a tick of 0 is taken with no result.
// Reset (rst_n low, synchronous): phase 0, phase_step 42852281, amplitude 16384,
// output empty.
module sine_oscillator_pcm_top
  import sop_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [PHASE_W-1:0]      cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_tick,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PCM_W-1:0] out_pcm_sample
);

  localparam logic [MUL_B_W-1:0] FULL_SCALE = MUL_B_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam int MAG_W = PROD_W - Q30_SHIFT;

  logic [PHASE_W-1:0] phase_step_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic [PHASE_W-1:0] phase_acc_r;
  logic               neg_r;
  sop_state_t         state_r;
  sop_state_t         state_nxt;
  logic               out_valid_r;
  logic [PCM_W-1:0]   out_pcm_r;

  logic                    in_accept;
  logic                    start;
  logic                    out_load;
  mul_ctl_t                mul_ctl;
  logic [TABLE_ADDR_BITS-1:0] tab_idx;
  logic [TABLE_ADDR_BITS:0]   tab_addr;
  logic [SINE_W-1:0]       sine;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        mag_full;
  logic [MUL_B_W-1:0]      mag_lim;
  logic [PCM_MAG_W-1:0]    mag;
  logic [PCM_W-1:0]        sample;

  assign in_stall = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign start = in_accept && in_tick;

  // Odd quadrants read the table mirrored
  assign tab_idx = phase_acc_r[PHASE_W-3 -: TABLE_ADDR_BITS];
  assign tab_addr = phase_acc_r[PHASE_W-2]
                  ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, tab_idx})
                  : {1'b0, tab_idx};

  sop_rom #(
    .ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (start),
    .rd_addr(tab_addr),
    .rd_data(sine)
  );

  sop_mul u_mul (
    .clk       (clk),
    .ctl       (mul_ctl),
    .sine      (sine),
    .amplitude (amplitude_r),
    .full_scale(FULL_SCALE),
    .prod      (prod)
  );

  // Saturate at full scale, then at the 15-bit magnitude field
  assign mag_full = prod[PROD_W-1:Q30_SHIFT];
  assign mag_lim = (mag_full > MAG_W'(FULL_SCALE)) ? FULL_SCALE : mag_full[MUL_B_W-1:0];
  assign mag = (mag_lim > MUL_B_W'(PCM_MAG_MAX)) ? PCM_MAG_MAX : mag_lim[PCM_MAG_W-1:0];
  assign sample = neg_r ? (PCM_W'(0) - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    state_nxt = state_r;
    mul_ctl.en = 1'b0;
    mul_ctl.op = MUL_GAIN;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        mul_ctl.en = 1'b1;
        mul_ctl.op = MUL_GAIN;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        mul_ctl.en = 1'b1;
        mul_ctl.op = MUL_SCALE;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_W'(42852281);
      amplitude_r <= AMP_W'(16384);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata;
        CFG_AMPLITUDE:  amplitude_r <= cfg_wdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the phase once the current one has been sampled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (start) begin
      phase_acc_r <= phase_acc_r + phase_step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= phase_acc_r[PHASE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pcm_r <= sample;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pcm_sample = out_pcm_r;

endmodule

[hw/rtl/sop_checker.sv]
module sop_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_tick,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [15:0] out_pcm_sample
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pcm_sample))
    else $error("output word changed while stalled");

  // magnitude never reaches the most negative code
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pcm_sample != 16'sh8000)
    else $error("sample hit -32768");

  // a real tick keeps the input busy while the sample is built
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_tick |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input ready too soon after a tick");

  // an empty tick costs nothing
  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_tick |=> !in_stall)
    else $error("input stalled after an empty tick");

endmodule

bind sine_oscillator_pcm_top sop_checker u_sop_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_tick       (in_tick),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pcm_sample(out_pcm_sample)
);
